>>> hdl/dek_pkg.sv
// ----------------------------------------------------------------------------
// dek_pkg: shared types and constants for the DIS event kinematics block
// Field widths, register indexes, status codes and saturation bounds.
// ----------------------------------------------------------------------------
package dek_pkg;

  // result field widths
  localparam int W_W    = 26;
  localparam int Q2_W   = 52;
  localparam int NU_W   = 26;
  localparam int FIX_W  = 20;
  localparam int STAT_W = 2;

  // configuration register widths
  localparam int EB_W = 24;
  localparam int MP_W = 21;
  localparam int ME_W = 12;
  localparam int TH_W = 24;
  localparam int EE_W = 24;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BEAM   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROTON = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ELEC   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CUT    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH = 3'd4;

  // register reset values
  localparam logic [EB_W-1:0] BEAM_RST   = 24'd10600000;
  localparam logic [MP_W-1:0] PROTON_RST = 21'd938272;
  localparam logic [ME_W-1:0] ELEC_RST   = 12'd511;
  localparam logic [TH_W-1:0] THRESH_RST = 24'd2000000;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_CUT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT  = 2'd3;

  // internal widths
  localparam int RAD_W  = 52;  // W radicand
  localparam int ROOT_W = 26;  // W root
  localparam int DX_W   = 47;  // 2*Mp*|nu|
  localparam int QM_W   = 25;  // |nu|

  // saturation bounds
  localparam logic signed [W_W-1:0]  W_POS_MAX  = 26'sh1FFFFFF;
  localparam logic signed [W_W-1:0]  W_NEG_MAX  = 26'sh2000000;
  localparam logic signed [Q2_W-1:0] Q2_POS_MAX = {1'b0, {(Q2_W-1){1'b1}}};
  localparam logic signed [Q2_W-1:0] Q2_NEG_MAX = {1'b1, {(Q2_W-1){1'b0}}};
  localparam logic [FIX_W-1:0]       FIX_POS_MAX = 20'h7FFFF;
  localparam logic [FIX_W-1:0]       FIX_NEG_MAX = 20'h80000;
  // (2^25 + 1)^2: smallest negative-side radicand whose root exceeds 2^25
  localparam logic [63:0] W_NEG_SAT_SQ = 64'h0004_0000_0400_0001;
  localparam logic [63:0] Q2_MAG_HALF  = 64'h0008_0000_0000_0000;

  // side data that travels with an item through the root and divide stages
  typedef struct packed {
    logic signed [Q2_W-1:0] q2;
    logic signed [NU_W-1:0] q0;
    logic [DX_W-1:0]        dx;
    logic                   q2sat;
    logic                   wsat;
    logic                   wneg;
    logic                   zx;
    logic                   zy;
  } dek_side_t;

endpackage

>>> hdl/dek_in_if.sv
// ----------------------------------------------------------------------------
// dek_in_if: scattered electron item channel
// Valid/ready channel carrying one electron four-momentum per item.
// ----------------------------------------------------------------------------
interface dek_in_if #(
  parameter int MOMENTUM_BITS = 25
);
  logic                            valid;
  logic                            ready;
  logic signed [MOMENTUM_BITS-1:0] electron_px_kev;
  logic signed [MOMENTUM_BITS-1:0] electron_py_kev;
  logic signed [MOMENTUM_BITS-1:0] electron_pz_kev;
  logic [23:0]                     electron_e_kev;

  modport source (
    output valid, electron_px_kev, electron_py_kev, electron_pz_kev, electron_e_kev,
    input  ready
  );
  modport sink (
    input  valid, electron_px_kev, electron_py_kev, electron_pz_kev, electron_e_kev,
    output ready
  );
endinterface

>>> hdl/dek_out_if.sv
// ----------------------------------------------------------------------------
// dek_out_if: kinematics result channel
// Valid/ready channel carrying W, Q2, nu, x, y and status per item.
// ----------------------------------------------------------------------------
interface dek_out_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] w_kev;
  logic signed [51:0] q2_kev2;
  logic signed [25:0] nu_kev;
  logic signed [19:0] bjorken_x;
  logic signed [19:0] inelasticity_y;
  logic [1:0]         status;

  modport source (
    output valid, w_kev, q2_kev2, nu_kev, bjorken_x, inelasticity_y, status,
    input  ready
  );
  modport sink (
    input  valid, w_kev, q2_kev2, nu_kev, bjorken_x, inelasticity_y, status,
    output ready
  );
endinterface

>>> hdl/dek_cfg_if.sv
// ----------------------------------------------------------------------------
// dek_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface dek_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [23:0] data;

  modport source (
    output valid, addr, data,
    input  ready
  );
  modport sink (
    input  valid, addr, data,
    output ready
  );
endinterface

>>> hdl/dek_div.sv
// ----------------------------------------------------------------------------
// dek_div: pipelined fixed-point divider
// Computes floor(num * 2^FB / den) one quotient bit per stage, and flags a
// quotient of 2^FIX_W or more. One setup stage plus FIX_W bit stages.
// ----------------------------------------------------------------------------
module dek_div import dek_pkg::*; #(
  parameter int NW = 52,
  parameter int DW = 47,
  parameter int FB = 16
) (
  input  logic             clk,
  input  logic [FIX_W:0]   en,
  input  logic [NW-1:0]    num,
  input  logic [DW-1:0]    den,
  output logic [FIX_W-1:0] quo,
  output logic             big
);

  localparam int NXW = NW + FB;
  localparam int CW  = (NXW > DW) ? NXW : DW;

  logic [DW-1:0]    rem_r  [FIX_W+1];
  logic [DW-1:0]    den_r  [FIX_W+1];
  logic [FIX_W-1:0] quo_r  [FIX_W+1];
  logic [FIX_W-1:0] low_r  [FIX_W+1];
  logic             big_r  [FIX_W+1];

  // setup: scale numerator, check integer range, seed remainder
  logic [NXW-1:0] nx;
  logic [NXW-1:0] hi;
  assign nx = {num, {FB{1'b0}}};
  assign hi = nx >> FIX_W;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= DW'(hi);
      den_r[0] <= den;
      quo_r[0] <= '0;
      low_r[0] <= nx[FIX_W-1:0];
      big_r[0] <= CW'(hi) >= CW'(den);
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k <= FIX_W; k++) begin : g_step
    logic [DW:0] cur;
    logic        ge;
    assign cur = {rem_r[k-1], low_r[k-1][FIX_W-1]};
    assign ge  = cur >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? DW'(cur - {1'b0, den_r[k-1]}) : DW'(cur);
        den_r[k] <= den_r[k-1];
        quo_r[k] <= {quo_r[k-1][FIX_W-2:0], ge};
        low_r[k] <= {low_r[k-1][FIX_W-2:0], 1'b0};
        big_r[k] <= big_r[k-1];
      end
    end
  end

  assign quo = quo_r[FIX_W];
  assign big = big_r[FIX_W];

endmodule

>>> hdl/dis_event_kinematics.sv
// ----------------------------------------------------------------------------
// dis_event_kinematics: DIS kinematics from one scattered electron
// Computes W, Q2, nu, Bjorken x and inelasticity y against a fixed proton
// target and a beam along z.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one scattered-electron four-momentum per item, out_ch one
//   result item per input item, in order. cfg_ch writes the beam energy,
//   proton mass, electron mass, W cut enable and W threshold by index; it is
//   always ready, and the user must write it only while no item is in flight,
//   which the block does not enforce. From input accept to output valid an
//   item passes through the front end, squares, sums, differences, clamp,
//   then 26 root stages (one result bit each) with the x and y dividers
//   (20 quotient bits, one per stage) running alongside, then the output
//   register. Throughput is one item per cycle while out_ch does not stall
//   and the beam momentum is not being recomputed. The beam momentum is
//   recomputed by a sequential square root after reset and after every
//   configuration write; in_ch.ready stays low during that time.
//   When out_ch stalls, items keep entering until every stage holds one;
//   empty stages are squeezed out, nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module dis_event_kinematics import dek_pkg::*; #(
  parameter int MOMENTUM_BITS = 25,
  parameter int FRACTION_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  dek_in_if.sink   in_ch,
  dek_out_if.source out_ch,
  dek_cfg_if.sink  cfg_ch
);

  localparam int MB    = MOMENTUM_BITS;
  localparam int QZW   = ((MB > 25) ? MB : 25) + 1;
  localparam int S_SQ  = 5;
  localparam int NS    = S_SQ + ROOT_W + 1;
  localparam int S_DIV = NS - 2 - FIX_W;

  localparam logic [1:0] PB_IDLE = 2'd0;
  localparam logic [1:0] PB_LOAD = 2'd1;
  localparam logic [1:0] PB_RUN  = 2'd2;
  localparam int         PB_STEPS = 24;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [EB_W-1:0] beam_r;
  logic [MP_W-1:0] proton_r;
  logic [ME_W-1:0] elec_r;
  logic            cut_en_r;
  logic [TH_W-1:0] thresh_r;
  logic            cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_r   <= BEAM_RST;
      proton_r <= PROTON_RST;
      elec_r   <= ELEC_RST;
      cut_en_r <= 1'b0;
      thresh_r <= THRESH_RST;
    end else if (cfg_fire) begin
      case (cfg_ch.addr)
        REG_BEAM:   beam_r   <= cfg_ch.data[EB_W-1:0];
        REG_PROTON: proton_r <= cfg_ch.data[MP_W-1:0];
        REG_ELEC:   elec_r   <= cfg_ch.data[ME_W-1:0];
        REG_CUT:    cut_en_r <= cfg_ch.data[0];
        REG_THRESH: thresh_r <= cfg_ch.data[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // beam momentum: sequential square root of Eb^2 - me^2
  // --------------------------------------------------------------------------
  logic [1:0]  pb_state_r, pb_state_nxt;
  logic [4:0]  pb_cnt_r, pb_cnt_nxt;
  logic [47:0] pb_rad_r, pb_rad_nxt;
  logic [25:0] pb_rem_r, pb_rem_nxt;
  logic [23:0] pb_root_r, pb_root_nxt;
  logic [27:0] pb_cur, pb_trial;
  logic        pb_ge;

  assign pb_cur   = {pb_rem_r, pb_rad_r[47:46]};
  assign pb_trial = {2'b00, pb_root_r, 2'b01};
  assign pb_ge    = pb_cur >= pb_trial;

  always_comb begin
    pb_state_nxt = pb_state_r;
    pb_cnt_nxt   = pb_cnt_r;
    pb_rad_nxt   = pb_rad_r;
    pb_rem_nxt   = pb_rem_r;
    pb_root_nxt  = pb_root_r;
    case (pb_state_r)
      PB_LOAD: begin
        pb_rad_nxt   = (beam_r >= EB_W'(elec_r)) ?
                       (48'(beam_r) * 48'(beam_r)) - (48'(elec_r) * 48'(elec_r)) : '0;
        pb_rem_nxt   = '0;
        pb_root_nxt  = '0;
        pb_cnt_nxt   = '0;
        pb_state_nxt = PB_RUN;
      end
      PB_RUN: begin
        pb_rem_nxt  = pb_ge ? 26'(pb_cur - pb_trial) : 26'(pb_cur);
        pb_root_nxt = {pb_root_r[22:0], pb_ge};
        pb_rad_nxt  = {pb_rad_r[45:0], 2'b00};
        pb_cnt_nxt  = pb_cnt_r + 5'd1;
        if (pb_cnt_r == 5'(PB_STEPS - 1)) begin
          pb_state_nxt = PB_IDLE;
        end
      end
      PB_IDLE: ;
      default: pb_state_nxt = PB_IDLE;
    endcase
    // restart on any register write
    if (cfg_fire) begin
      pb_state_nxt = PB_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_state_r <= PB_LOAD;
      pb_cnt_r   <= '0;
    end else begin
      pb_state_r <= pb_state_nxt;
      pb_cnt_r   <= pb_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pb_rad_r  <= pb_rad_nxt;
    pb_rem_r  <= pb_rem_nxt;
    pb_root_r <= pb_root_nxt;
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage loads when empty or when it drains
  // --------------------------------------------------------------------------
  logic [NS-1:0] v_r, v_nxt;
  logic [NS-1:0] rdy;
  logic          in_fire;

  assign rdy[NS-1] = ~v_r[NS-1] | out_ch.ready;
  for (genvar s = 0; s < NS - 1; s++) begin : g_rdy
    assign rdy[s] = ~v_r[s] | rdy[s+1];
  end

  assign in_ch.ready = rdy[0] & (pb_state_r == PB_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign v_nxt       = {v_r[NS-2:0], in_fire};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_nxt[s];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: photon and hadron-system components, magnitudes
  // --------------------------------------------------------------------------
  logic signed [MB-1:0]  px_s, py_s, pz_s;
  logic signed [QZW-1:0] qz_s;
  logic signed [NU_W-1:0] q0_s;
  logic signed [26:0]    ew_s;

  logic [MB-1:0]          r0_axm, r0_aym;
  logic [QZW-1:0]         r0_qzm;
  logic signed [NU_W-1:0] r0_q0;
  logic [QM_W-1:0]        r0_qm;
  logic [25:0]            r0_ewm;

  assign px_s = in_ch.electron_px_kev;
  assign py_s = in_ch.electron_py_kev;
  assign pz_s = in_ch.electron_pz_kev;
  assign qz_s = $signed({{(QZW-24){1'b0}}, pb_root_r}) - QZW'(pz_s);
  assign q0_s = $signed({2'b00, beam_r}) - $signed({2'b00, in_ch.electron_e_kev});
  assign ew_s = $signed({3'b000, beam_r}) + $signed({6'b000000, proton_r})
              - $signed({3'b000, in_ch.electron_e_kev});

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      r0_axm <= px_s[MB-1] ? MB'(-px_s) : MB'(px_s);
      r0_aym <= py_s[MB-1] ? MB'(-py_s) : MB'(py_s);
      r0_qzm <= qz_s[QZW-1] ? QZW'(-qz_s) : QZW'(qz_s);
      r0_q0  <= q0_s;
      r0_qm  <= q0_s[NU_W-1] ? QM_W'(-q0_s) : QM_W'(q0_s);
      r0_ewm <= ew_s[26] ? 26'(-ew_s) : 26'(ew_s);
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: squares and x divisor
  // --------------------------------------------------------------------------
  logic [2*MB-1:0]        r1_sx, r1_sy;
  logic [2*QZW-1:0]       r1_sz;
  logic [51:0]            r1_ew2;
  logic [49:0]            r1_q02;
  logic signed [NU_W-1:0] r1_q0;
  logic [DX_W-1:0]        r1_dx;
  logic                   r1_zx, r1_zy;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      r1_sx  <= (2*MB)'(r0_axm) * (2*MB)'(r0_axm);
      r1_sy  <= (2*MB)'(r0_aym) * (2*MB)'(r0_aym);
      r1_sz  <= (2*QZW)'(r0_qzm) * (2*QZW)'(r0_qzm);
      r1_ew2 <= 52'(r0_ewm) * 52'(r0_ewm);
      r1_q02 <= 50'(r0_qm) * 50'(r0_qm);
      r1_q0  <= r0_q0;
      r1_dx  <= DX_W'({proton_r, 1'b0}) * DX_W'(r0_qm);
      r1_zx  <= (proton_r == '0) || (r0_q0 == '0);
      r1_zy  <= (beam_r == '0);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: |p_q|^2 with saturation at 64 bits
  // --------------------------------------------------------------------------
  logic [65:0]            psum;
  logic [63:0]            r2_psq;
  logic [51:0]            r2_ew2;
  logic [49:0]            r2_q02;
  logic signed [NU_W-1:0] r2_q0;
  logic [DX_W-1:0]        r2_dx;
  logic                   r2_zx, r2_zy;

  assign psum = 66'(r1_sx) + 66'(r1_sy) + 66'(r1_sz);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      r2_psq <= (|psum[65:64]) ? '1 : psum[63:0];
      r2_ew2 <= r1_ew2;
      r2_q02 <= r1_q02;
      r2_q0  <= r1_q0;
      r2_dx  <= r1_dx;
      r2_zx  <= r1_zx;
      r2_zy  <= r1_zy;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: mass-squared and Q2 differences
  // --------------------------------------------------------------------------
  logic [64:0]            r3_wd, r3_qd;
  logic signed [NU_W-1:0] r3_q0;
  logic [DX_W-1:0]        r3_dx;
  logic                   r3_zx, r3_zy;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      r3_wd <= {1'b0, 64'(r2_ew2)} - {1'b0, r2_psq};
      r3_qd <= {1'b0, r2_psq} - {1'b0, 64'(r2_q02)};
      r3_q0 <= r2_q0;
      r3_dx <= r2_dx;
      r3_zx <= r2_zx;
      r3_zy <= r2_zy;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: magnitudes, W saturation check, Q2 clamp
  // --------------------------------------------------------------------------
  logic [63:0]     wmag, qmag;
  logic            wneg, qneg;
  dek_side_t       side4_nxt;
  logic [RAD_W-1:0] r4_rad_r;

  assign wneg = r3_wd[64];
  assign qneg = r3_qd[64];
  assign wmag = wneg ? (64'd0 - r3_wd[63:0]) : r3_wd[63:0];
  assign qmag = qneg ? (64'd0 - r3_qd[63:0]) : r3_qd[63:0];

  always_comb begin
    side4_nxt.q0   = r3_q0;
    side4_nxt.dx   = r3_dx;
    side4_nxt.zx   = r3_zx;
    side4_nxt.zy   = r3_zy;
    side4_nxt.wneg = wneg;
    side4_nxt.wsat = wneg ? (wmag >= W_NEG_SAT_SQ) : (|wmag[63:50]);
    if (!qneg) begin
      side4_nxt.q2sat = |qmag[63:51];
      side4_nxt.q2    = side4_nxt.q2sat ? Q2_POS_MAX : $signed(qmag[Q2_W-1:0]);
    end else begin
      side4_nxt.q2sat = qmag > Q2_MAG_HALF;
      side4_nxt.q2    = (qmag >= Q2_MAG_HALF) ? Q2_NEG_MAX : $signed(Q2_W'(0) - qmag[Q2_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      r4_rad_r <= wmag[RAD_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // side data delay line, stages 4 to NS-2
  // --------------------------------------------------------------------------
  dek_side_t side_r [4:NS-2];

  for (genvar s = 4; s <= NS - 2; s++) begin : g_side
    if (s == 4) begin : g_head
      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          side_r[s] <= side4_nxt;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // W root: one result bit per stage
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0]  sq_rad_r  [S_SQ:NS-2];
  logic [ROOT_W+1:0] sq_rem_r  [S_SQ:NS-2];
  logic [ROOT_W-1:0] sq_root_r [S_SQ:NS-2];

  for (genvar s = S_SQ; s <= NS - 2; s++) begin : g_root
    logic [RAD_W-1:0]  p_rad;
    logic [ROOT_W+1:0] p_rem;
    logic [ROOT_W-1:0] p_root;
    logic [ROOT_W+3:0] cur, trial;
    logic              ge;

    if (s == S_SQ) begin : g_first
      assign p_rad  = r4_rad_r;
      assign p_rem  = '0;
      assign p_root = '0;
    end else begin : g_next
      assign p_rad  = sq_rad_r[s-1];
      assign p_rem  = sq_rem_r[s-1];
      assign p_root = sq_root_r[s-1];
    end

    assign cur   = {p_rem, p_rad[RAD_W-1 -: 2]};
    assign trial = {2'b00, p_root, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        sq_rem_r[s]  <= ge ? (ROOT_W+2)'(cur - trial) : (ROOT_W+2)'(cur);
        sq_root_r[s] <= {p_root[ROOT_W-2:0], ge};
        sq_rad_r[s]  <= {p_rad[RAD_W-3:0], 2'b00};
      end
    end
  end

  // --------------------------------------------------------------------------
  // x and y dividers, aligned to finish with the root
  // --------------------------------------------------------------------------
  dek_side_t        side_dv;
  logic [Q2_W-1:0]  x_num;
  logic [QM_W-1:0]  y_num;
  logic [FIX_W-1:0] x_quo, y_quo;
  logic             x_big, y_big;

  assign side_dv = side_r[S_DIV-1];
  assign x_num   = side_dv.q2[Q2_W-1] ? Q2_W'(-side_dv.q2) : Q2_W'(side_dv.q2);
  assign y_num   = side_dv.q0[NU_W-1] ? QM_W'(-side_dv.q0) : QM_W'(side_dv.q0);

  dek_div #(
    .NW (Q2_W),
    .DW (DX_W),
    .FB (FRACTION_BITS)
  ) u_div_x (
    .clk (clk),
    .en  (rdy[S_DIV +: FIX_W+1]),
    .num (x_num),
    .den (side_dv.dx),
    .quo (x_quo),
    .big (x_big)
  );

  dek_div #(
    .NW (QM_W),
    .DW (EB_W),
    .FB (FRACTION_BITS)
  ) u_div_y (
    .clk (clk),
    .en  (rdy[S_DIV +: FIX_W+1]),
    .num (y_num),
    .den (beam_r),
    .quo (y_quo),
    .big (y_big)
  );

  // --------------------------------------------------------------------------
  // output stage: sign, saturate, apply W cut, build status
  // --------------------------------------------------------------------------
  dek_side_t              side_f;
  logic [ROOT_W-1:0]      root_f;
  logic signed [W_W-1:0]  w_val;
  logic                   x_neg, y_neg, x_sat, y_sat, cut, any_sat;
  logic signed [FIX_W-1:0] x_val, y_val;

  logic signed [W_W-1:0]   out_w_r;
  logic signed [Q2_W-1:0]  out_q2_r;
  logic signed [NU_W-1:0]  out_nu_r;
  logic signed [FIX_W-1:0] out_x_r, out_y_r;
  logic [STAT_W-1:0]       out_st_r;

  assign side_f = side_r[NS-2];
  assign root_f = sq_root_r[NS-2];

  always_comb begin
    if (side_f.wsat) begin
      w_val = side_f.wneg ? W_NEG_MAX : W_POS_MAX;
    end else begin
      w_val = side_f.wneg ? $signed(W_W'(0) - root_f) : $signed(root_f);
    end
    cut = cut_en_r && (w_val < $signed({2'b00, thresh_r}));

    // x: sign follows Q2 and nu
    x_neg = side_f.q2[Q2_W-1] != side_f.q0[NU_W-1];
    x_sat = x_big || (x_neg ? (x_quo[FIX_W-1] && (|x_quo[FIX_W-2:0])) : x_quo[FIX_W-1]);
    if (side_f.zx) begin
      x_val = '0;
    end else if (x_sat) begin
      x_val = x_neg ? $signed(FIX_NEG_MAX) : $signed(FIX_POS_MAX);
    end else begin
      x_val = x_neg ? $signed(FIX_W'(0) - x_quo) : $signed(x_quo);
    end

    // y: sign follows nu
    y_neg = side_f.q0[NU_W-1];
    y_sat = y_big || (y_neg ? (y_quo[FIX_W-1] && (|y_quo[FIX_W-2:0])) : y_quo[FIX_W-1]);
    if (side_f.zy) begin
      y_val = '0;
    end else if (y_sat) begin
      y_val = y_neg ? $signed(FIX_NEG_MAX) : $signed(FIX_POS_MAX);
    end else begin
      y_val = y_neg ? $signed(FIX_W'(0) - y_quo) : $signed(y_quo);
    end

    any_sat = side_f.wsat || side_f.q2sat || (x_sat && !side_f.zx) || (y_sat && !side_f.zy);
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      out_w_r <= w_val;
      if (cut) begin
        out_q2_r <= '0;
        out_nu_r <= '0;
        out_x_r  <= '0;
        out_y_r  <= '0;
        out_st_r <= ST_CUT;
      end else begin
        out_q2_r <= side_f.q2;
        out_nu_r <= side_f.q0;
        out_x_r  <= x_val;
        out_y_r  <= y_val;
        out_st_r <= (side_f.zx || side_f.zy) ? ST_ZERO : (any_sat ? ST_SAT : ST_OK);
      end
    end
  end

  assign out_ch.valid          = v_r[NS-1];
  assign out_ch.w_kev          = out_w_r;
  assign out_ch.q2_kev2        = out_q2_r;
  assign out_ch.nu_kev         = out_nu_r;
  assign out_ch.bjorken_x      = out_x_r;
  assign out_ch.inelasticity_y = out_y_r;
  assign out_ch.status         = out_st_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_cut_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_CUT |->
      out_ch.q2_kev2 == '0 && out_ch.nu_kev == '0 &&
      out_ch.bjorken_x == '0 && out_ch.inelasticity_y == '0)
    else $error("cut item carries nonzero results");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> !in_fire)
    else $error("item accepted while beam momentum recomputes");

  a_zero_beam: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && beam_r == '0 && out_ch.status != ST_CUT |->
      out_ch.status == ST_ZERO && out_ch.inelasticity_y == '0)
    else $error("zero beam energy not flagged");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v_r[0])
    else $error("accepted item lost at pipeline entry");

endmodule
